FILE: design/tfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_pkg: shared constants for the timing feedback classifier
// Field widths, coach state codes, register indexes, reset values and holds.
// ----------------------------------------------------------------------------
package tfc_pkg;

    localparam int MEAN_W   = 21;
    localparam int US_W     = 20;
    localparam int MS_W     = 32;
    localparam int STAB_W   = 10;
    localparam int STATE_W  = 3;
    localparam int HOLD_W   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [STATE_W-1:0] coach_state_t;
    typedef logic [HOLD_W-1:0]  hold_t;

    // coach state codes
    localparam coach_state_t ST_NEUTRAL  = 3'd0;
    localparam coach_state_t ST_RUSHING  = 3'd1;
    localparam coach_state_t ST_DRAGGING = 3'd2;
    localparam coach_state_t ST_POCKET   = 3'd3;
    localparam coach_state_t ST_RELAX    = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POCKET_MEAN_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POCKET_JITTER_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_WINDOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELAX_START        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELAX_MIN_BASELINE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RELAX_DROP         = 3'd6;

    // register reset values
    localparam logic [US_W-1:0]   RST_DRIFT_THRESHOLD     = 20'd10000;
    localparam logic [US_W-1:0]   RST_POCKET_MEAN_LIMIT   = 20'd3000;
    localparam logic [US_W-1:0]   RST_POCKET_JITTER_LIMIT = 20'd5000;
    localparam logic [MS_W-1:0]   RST_BASELINE_WINDOW     = 32'd120000;
    localparam logic [MS_W-1:0]   RST_RELAX_START         = 32'd300000;
    localparam logic [STAB_W-1:0] RST_RELAX_MIN_BASELINE  = 10'd850;
    localparam logic [STAB_W-1:0] RST_RELAX_DROP          = 10'd150;

    // hold counts loaded on entering a state
    localparam hold_t HOLD_STEADY = 5'd16;
    localparam hold_t HOLD_RELAX  = 5'd24;

endpackage

FILE: design/timing_feedback_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timing_feedback_classifier_unit: per-beat timing coach classifier
// Tracks a baseline stability, then classifies each beat as relax, in pocket,
// rushing, dragging or neutral with a hold counter for hysteresis.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid / in_stall    | data_valid, mean_deviation_us,
//          |                        | jitter_us, stability, elapsed_ms
//  out     | out_valid / out_stall  | coach_state, flow
//  cfg     | cfg_write              | cfg_index, cfg_data
//
//  One beat in and one beat out per cycle while out_stall is low; a beat
//  passes the input register, then is classified and its state update
//  loaded into the result register. The throughput is set by the single
//  classify stage, which closes the loop of state, hold, baseline and lock.
//  Reset clears the state, the hold counter, the baseline and both valid
//  flags, and loads every configuration register with its default.
//  A stalled result holds; in_stall rises only when the input register is
//  full and the result register cannot drain in the same cycle.
//
module timing_feedback_classifier_unit
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [tfc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tfc_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                data_valid,
    input  logic signed [tfc_pkg::MEAN_W-1:0]   mean_deviation_us,
    input  logic [tfc_pkg::US_W-1:0]            jitter_us,
    input  logic [tfc_pkg::STAB_W-1:0]          stability,
    input  logic [tfc_pkg::MS_W-1:0]            elapsed_ms,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tfc_pkg::STATE_W-1:0]         coach_state,
    output logic                                flow
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [tfc_pkg::US_W-1:0]   drift_reg;
    logic [tfc_pkg::US_W-1:0]   pocket_mean_reg;
    logic [tfc_pkg::US_W-1:0]   pocket_jitter_reg;
    logic [tfc_pkg::MS_W-1:0]   window_reg;
    logic [tfc_pkg::MS_W-1:0]   relax_start_reg;
    logic [tfc_pkg::STAB_W-1:0] relax_min_reg;
    logic [tfc_pkg::STAB_W-1:0] relax_drop_reg;

    // Truncate the write data to each register's width; drop unknown indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drift_reg         <= tfc_pkg::RST_DRIFT_THRESHOLD;
            pocket_mean_reg   <= tfc_pkg::RST_POCKET_MEAN_LIMIT;
            pocket_jitter_reg <= tfc_pkg::RST_POCKET_JITTER_LIMIT;
            window_reg        <= tfc_pkg::RST_BASELINE_WINDOW;
            relax_start_reg   <= tfc_pkg::RST_RELAX_START;
            relax_min_reg     <= tfc_pkg::RST_RELAX_MIN_BASELINE;
            relax_drop_reg    <= tfc_pkg::RST_RELAX_DROP;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tfc_pkg::REG_DRIFT_THRESHOLD:
                    drift_reg <= cfg_data[tfc_pkg::US_W-1:0];
                tfc_pkg::REG_POCKET_MEAN_LIMIT:
                    pocket_mean_reg <= cfg_data[tfc_pkg::US_W-1:0];
                tfc_pkg::REG_POCKET_JITTER_LIMIT:
                    pocket_jitter_reg <= cfg_data[tfc_pkg::US_W-1:0];
                tfc_pkg::REG_BASELINE_WINDOW:
                    window_reg <= cfg_data[tfc_pkg::MS_W-1:0];
                tfc_pkg::REG_RELAX_START:
                    relax_start_reg <= cfg_data[tfc_pkg::MS_W-1:0];
                tfc_pkg::REG_RELAX_MIN_BASELINE:
                    relax_min_reg <= cfg_data[tfc_pkg::STAB_W-1:0];
                tfc_pkg::REG_RELAX_DROP:
                    relax_drop_reg <= cfg_data[tfc_pkg::STAB_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the classify stage, which writes the
    // result register. The input register advances whenever the result
    // register is empty or being drained this cycle.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic s1_advance;
    logic in_take;

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_take    = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload register: capture on every accepted beat.
    logic                              s1_data_valid_reg;
    logic signed [tfc_pkg::MEAN_W-1:0] s1_mean_reg;
    logic [tfc_pkg::US_W-1:0]          s1_jitter_reg;
    logic [tfc_pkg::STAB_W-1:0]        s1_stab_reg;
    logic [tfc_pkg::MS_W-1:0]          s1_elapsed_reg;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_valid_reg <= data_valid;
            s1_mean_reg       <= mean_deviation_us;
            s1_jitter_reg     <= jitter_us;
            s1_stab_reg       <= stability;
            s1_elapsed_reg    <= elapsed_ms;
        end
    end

    // ------------------------------------------------------------------
    // Classify stage
    // ------------------------------------------------------------------
    logic [tfc_pkg::STATE_W-1:0] state_reg;
    logic [tfc_pkg::STATE_W-1:0] state_next;
    logic [tfc_pkg::HOLD_W-1:0]  hold_reg;
    logic [tfc_pkg::HOLD_W-1:0]  hold_next;
    logic [tfc_pkg::STAB_W-1:0]  baseline_reg;
    logic [tfc_pkg::STAB_W-1:0]  baseline_next;
    logic                        locked_reg;
    logic                        locked_next;

    logic signed [tfc_pkg::MEAN_W:0] mean_ext;
    logic signed [tfc_pkg::MEAN_W:0] drift_ext;
    logic [tfc_pkg::MEAN_W-1:0]      abs_mean;
    logic [tfc_pkg::STAB_W:0]        stab_plus_drop;
    logic [tfc_pkg::HOLD_W-1:0]      hold_dec;
    logic                            rushing;
    logic                            dragging;
    logic                            pocket;
    logic                            relax;

    assign mean_ext  = {s1_mean_reg[tfc_pkg::MEAN_W-1], s1_mean_reg};
    assign drift_ext = $signed({2'b00, drift_reg});
    // Negating the most negative mean wraps to the right unsigned magnitude.
    assign abs_mean  = s1_mean_reg[tfc_pkg::MEAN_W-1]
                     ? tfc_pkg::MEAN_W'(-s1_mean_reg)
                     : tfc_pkg::MEAN_W'(s1_mean_reg);
    assign stab_plus_drop = {1'b0, s1_stab_reg} + {1'b0, relax_drop_reg};
    assign hold_dec = (hold_reg == '0) ? hold_reg : hold_reg - 1'b1;

    always_comb
    begin
        // Baseline: track the peak inside the window; lock on the first beat
        // past it, falling back to the current score when the peak is zero.
        baseline_next = baseline_reg;
        locked_next   = locked_reg;
        if (s1_elapsed_reg < window_reg)
        begin
            if (s1_stab_reg > baseline_reg)
                baseline_next = s1_stab_reg;
        end
        else if (!locked_reg)
        begin
            locked_next = 1'b1;
            if (baseline_reg == '0)
                baseline_next = s1_stab_reg;
        end

        rushing  = s1_data_valid_reg && (mean_ext <= -drift_ext);
        dragging = s1_data_valid_reg && (mean_ext >= drift_ext);
        pocket   = s1_data_valid_reg
                && (abs_mean <= {1'b0, pocket_mean_reg})
                && (s1_jitter_reg <= pocket_jitter_reg);
        relax    = (s1_elapsed_reg >= relax_start_reg) && locked_next
                && (baseline_next >= relax_min_reg)
                && (stab_plus_drop <= {1'b0, baseline_next});

        // Priority: relax (if not yet relaxed), pocket, rushing, dragging,
        // then neutral once the hold runs out. A kept state counts it down.
        state_next = state_reg;
        hold_next  = hold_dec;
        if (relax && state_reg != tfc_pkg::ST_RELAX)
        begin
            state_next = tfc_pkg::ST_RELAX;
            hold_next  = tfc_pkg::HOLD_RELAX;
        end
        else if (pocket)
        begin
            if (state_reg != tfc_pkg::ST_POCKET)
            begin
                state_next = tfc_pkg::ST_POCKET;
                hold_next  = tfc_pkg::HOLD_STEADY;
            end
        end
        else if (rushing)
        begin
            if (state_reg != tfc_pkg::ST_RUSHING)
            begin
                state_next = tfc_pkg::ST_RUSHING;
                hold_next  = tfc_pkg::HOLD_STEADY;
            end
        end
        else if (dragging)
        begin
            if (state_reg != tfc_pkg::ST_DRAGGING)
            begin
                state_next = tfc_pkg::ST_DRAGGING;
                hold_next  = tfc_pkg::HOLD_STEADY;
            end
        end
        else if (hold_dec == '0)
        begin
            state_next = tfc_pkg::ST_NEUTRAL;
        end
    end

    // Commit the state only when a beat leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tfc_pkg::ST_NEUTRAL;
            hold_reg     <= '0;
            baseline_reg <= '0;
            locked_reg   <= 1'b0;
        end
        else if (s1_advance)
        begin
            state_reg    <= state_next;
            hold_reg     <= hold_next;
            baseline_reg <= baseline_next;
            locked_reg   <= locked_next;
        end
    end

    // Result register: load with the new state as the beat advances.
    logic [tfc_pkg::STATE_W-1:0] out_state_reg;
    logic                        out_flow_reg;

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_state_reg <= state_next;
            out_flow_reg  <= (state_next == tfc_pkg::ST_POCKET);
        end
    end

    assign out_valid   = out_valid_reg;
    assign coach_state = out_state_reg;
    assign flow        = out_flow_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Neutral is only ever entered or kept with the hold run out.
    a_neutral_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tfc_pkg::ST_NEUTRAL) |-> (hold_reg == '0))
        else $error("hold counter running while neutral");

    // The hold never exceeds the longest load.
    a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg <= tfc_pkg::HOLD_RELAX)
        else $error("hold counter above relax hold");

    // Backpressure only with a beat waiting in the input register.
    a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with nothing blocked");

    // Once locked, the baseline lock never drops.
    a_lock_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        $past(locked_reg) |-> locked_reg)
        else $error("baseline lock lost");

endmodule
